// File: design/ile_pkg.sv
// Shared types and constants for the indexed list engine.
// Holds capacity, derived widths, request kinds, status codes and the sequencer state type.
// No dependencies.
`default_nettype none

package ile_pkg;

   localparam int CAPACITY = 16;

   // fixed field widths of the request and response
   localparam int KIND_W  = 3;
   localparam int VALUE_W = 32;
   localparam int INDEX_W = 5;
   localparam int STAT_W  = 2;
   localparam int LEN_W   = 5;

   // derived storage widths
   localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int CMP_W  = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

   localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 40;

   localparam logic [KIND_W-1:0] KIND_APPEND   = 3'd0;
   localparam logic [KIND_W-1:0] KIND_INSERT   = 3'd1;
   localparam logic [KIND_W-1:0] KIND_POP      = 3'd2;
   localparam logic [KIND_W-1:0] KIND_POP_FALL = 3'd3;
   localparam logic [KIND_W-1:0] KIND_REMOVE   = 3'd4;

   localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STAT_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STAT_W-1:0] STATUS_RANGE = 2'd2;
   localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UP,
      ST_FILL,
      ST_DOWN,
      ST_DONE
   } state_type;

endpackage

`default_nettype wire

// File: design/indexed_list_engine_core.sv
// Indexed list engine top level: ordered list of signed words in one synchronous RAM (ile_pkg).
// An append, an insert at the end (index i equal to the length L) and a failed or ignored
// request go straight to completion; an insert below L shifts the words from i upward and then
// writes the value, pop takes the last word and remove shifts the words above i downward.
// The block takes one request at a time; each shift step moves one word.
// Reset clears the length, the sequencer and the response valid flag; element storage is not cleared.
`default_nettype none

module indexed_list_engine_core (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // [31:0] value, [36:32] index, [39:37] zero
   input  wire logic [ile_pkg::REQ_DATA_W-1:0]   req_tdata,
   // [2:0] kind
   input  wire logic [ile_pkg::KIND_W-1:0]       req_tuser,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // [31:0] data, [36:32] new_length, [39:37] zero
   output logic [ile_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   // [1:0] status
   output logic [ile_pkg::STAT_W-1:0]            rsp_tuser
);

   localparam int AW = ile_pkg::ADDR_W;
   localparam int CW = ile_pkg::CNT_W;
   localparam int XW = ile_pkg::CMP_W;
   localparam int VW = ile_pkg::VALUE_W;

   // element storage
   logic signed [VW-1:0] elements_mem [ile_pkg::CAPACITY];
   logic signed [VW-1:0] rd_data_ff;
   logic                 mem_re;
   logic [AW-1:0]        mem_raddr;
   logic                 mem_we;
   logic [AW-1:0]        mem_waddr;
   logic signed [VW-1:0] mem_wdata;

   ile_pkg::state_type state_ff, state_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [AW-1:0]        src_ff, src_in;
   logic [AW-1:0]        idx_ff, idx_in;
   logic [AW-1:0]        last_ff, last_in;
   logic signed [VW-1:0] value_ff, value_in;
   logic [ile_pkg::STAT_W-1:0] pend_status_ff, pend_status_in;
   logic signed [VW-1:0] pend_data_ff, pend_data_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic [ile_pkg::STAT_W-1:0] rsp_status_ff, rsp_status_in;
   logic signed [VW-1:0]       rsp_data_ff, rsp_data_in;
   logic [ile_pkg::LEN_W-1:0]  rsp_len_ff, rsp_len_in;

   logic                        req_fire;
   logic                        slot_free;
   logic [ile_pkg::KIND_W-1:0]  req_kind;
   logic signed [VW-1:0]        req_value;
   logic [XW-1:0]               req_idx_x;
   logic [XW-1:0]               count_x;
   logic [CW-1:0]               count_m1;
   logic                        full;
   logic                        empty;

   assign req_kind  = req_tuser;
   assign req_value = req_tdata[VW-1:0];
   assign req_idx_x = XW'(req_tdata[VW +: ile_pkg::INDEX_W]);
   assign count_x   = XW'(count_ff);
   assign count_m1  = count_ff - 1'b1;
   assign full      = (count_ff == ile_pkg::CAP_CNT);
   assign empty     = (count_ff == '0);

   assign req_tready = (state_ff == ile_pkg::ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign slot_free  = !rsp_valid_ff || rsp_tready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ile_pkg::ST_IDLE: begin
            if (req_fire) begin
               state_in = ile_pkg::ST_DONE;
               case (req_kind)
                  ile_pkg::KIND_INSERT: begin
                     if (!full && req_idx_x < count_x) begin
                        state_in = ile_pkg::ST_UP;
                     end
                  end
                  ile_pkg::KIND_POP, ile_pkg::KIND_POP_FALL: begin
                     if (!empty) begin
                        state_in = ile_pkg::ST_DOWN;
                     end
                  end
                  ile_pkg::KIND_REMOVE: begin
                     if (!empty && req_idx_x < count_x) begin
                        state_in = ile_pkg::ST_DOWN;
                     end
                  end
                  default: begin
                     state_in = ile_pkg::ST_DONE;
                  end
               endcase
            end
         end
         ile_pkg::ST_UP: begin
            if (src_ff == idx_ff) begin
               state_in = ile_pkg::ST_FILL;
            end
         end
         ile_pkg::ST_FILL: begin
            state_in = ile_pkg::ST_DONE;
         end
         ile_pkg::ST_DOWN: begin
            if (src_ff == last_ff) begin
               state_in = ile_pkg::ST_DONE;
            end
         end
         ile_pkg::ST_DONE: begin
            if (slot_free) begin
               state_in = ile_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ile_pkg::ST_IDLE;
         end
      endcase
   end

   // datapath and memory control
   // Shifts read ahead of the write address (below it moving up, above it moving down),
   // so a read never meets a word written earlier in the same request.
   always_comb begin
      mem_re         = 1'b0;
      mem_raddr      = src_ff;
      mem_we         = 1'b0;
      mem_waddr      = src_ff;
      mem_wdata      = rd_data_ff;
      count_in       = count_ff;
      src_in         = src_ff;
      idx_in         = idx_ff;
      last_in        = last_ff;
      value_in       = value_ff;
      pend_status_in = pend_status_ff;
      pend_data_in   = pend_data_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_status_in  = rsp_status_ff;
      rsp_data_in    = rsp_data_ff;
      rsp_len_in     = rsp_len_ff;
      case (state_ff)
         ile_pkg::ST_IDLE: begin
            if (req_fire) begin
               value_in       = req_value;
               pend_status_in = ile_pkg::STATUS_OK;
               pend_data_in   = '0;
               case (req_kind)
                  ile_pkg::KIND_APPEND: begin
                     if (full) begin
                        pend_status_in = ile_pkg::STATUS_FULL;
                     end else begin
                        mem_we    = 1'b1;
                        mem_waddr = count_ff[AW-1:0];
                        mem_wdata = req_value;
                        count_in  = count_ff + 1'b1;
                     end
                  end
                  ile_pkg::KIND_INSERT: begin
                     if (full) begin
                        pend_status_in = ile_pkg::STATUS_FULL;
                     end else if (req_idx_x > count_x) begin
                        pend_status_in = ile_pkg::STATUS_RANGE;
                     end else if (req_idx_x == count_x) begin
                        mem_we    = 1'b1;
                        mem_waddr = count_ff[AW-1:0];
                        mem_wdata = req_value;
                        count_in  = count_ff + 1'b1;
                     end else begin
                        mem_re    = 1'b1;
                        mem_raddr = count_m1[AW-1:0];
                        src_in    = count_m1[AW-1:0];
                        idx_in    = req_idx_x[AW-1:0];
                        count_in  = count_ff + 1'b1;
                     end
                  end
                  ile_pkg::KIND_POP, ile_pkg::KIND_POP_FALL: begin
                     if (empty) begin
                        pend_status_in = ile_pkg::STATUS_EMPTY;
                        if (req_kind == ile_pkg::KIND_POP_FALL) begin
                           pend_data_in = req_value;
                        end
                     end else begin
                        // pop is a remove of the last element
                        mem_re    = 1'b1;
                        mem_raddr = count_m1[AW-1:0];
                        src_in    = count_m1[AW-1:0];
                        idx_in    = count_m1[AW-1:0];
                        last_in   = count_m1[AW-1:0];
                        count_in  = count_m1;
                     end
                  end
                  ile_pkg::KIND_REMOVE: begin
                     if (empty) begin
                        pend_status_in = ile_pkg::STATUS_EMPTY;
                     end else if (req_idx_x >= count_x) begin
                        pend_status_in = ile_pkg::STATUS_RANGE;
                     end else begin
                        mem_re    = 1'b1;
                        mem_raddr = req_idx_x[AW-1:0];
                        src_in    = req_idx_x[AW-1:0];
                        idx_in    = req_idx_x[AW-1:0];
                        last_in   = count_m1[AW-1:0];
                        count_in  = count_m1;
                     end
                  end
                  default: begin
                     pend_status_in = ile_pkg::STATUS_OK;
                  end
               endcase
            end
         end
         ile_pkg::ST_UP: begin
            mem_we    = 1'b1;
            mem_waddr = src_ff + 1'b1;
            mem_wdata = rd_data_ff;
            if (src_ff != idx_ff) begin
               mem_re    = 1'b1;
               mem_raddr = src_ff - 1'b1;
               src_in    = src_ff - 1'b1;
            end
         end
         ile_pkg::ST_FILL: begin
            mem_we    = 1'b1;
            mem_waddr = idx_ff;
            mem_wdata = value_ff;
         end
         ile_pkg::ST_DOWN: begin
            // the first word read is the one leaving the list
            if (src_ff == idx_ff) begin
               pend_data_in = rd_data_ff;
            end else begin
               mem_we    = 1'b1;
               mem_waddr = src_ff - 1'b1;
               mem_wdata = rd_data_ff;
            end
            if (src_ff != last_ff) begin
               mem_re    = 1'b1;
               mem_raddr = src_ff + 1'b1;
               src_in    = src_ff + 1'b1;
            end
         end
         ile_pkg::ST_DONE: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = pend_status_ff;
               rsp_data_in   = pend_data_ff;
               rsp_len_in    = count_x[ile_pkg::LEN_W-1:0];
            end
         end
         default: begin
            mem_re = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         elements_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= elements_mem[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ile_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      src_ff         <= src_in;
      idx_ff         <= idx_in;
      last_ff        <= last_in;
      value_ff       <= value_in;
      pend_status_ff <= pend_status_in;
      pend_data_ff   <= pend_data_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_data_ff    <= rsp_data_in;
      rsp_len_ff     <= rsp_len_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {{(ile_pkg::RSP_DATA_W - VW - ile_pkg::LEN_W){1'b0}},
                        rsp_len_ff, rsp_data_ff};

`ifndef SYNTHESIS
   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= ile_pkg::CAP_CNT)
      else $error("list length above capacity");

   a_count_moves_on_request: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && count_ff != $past(count_ff)) |-> $past(req_tvalid && req_tready))
      else $error("length changed without an accepted request");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $rose(rsp_valid_ff)) |-> $past(state_ff == ile_pkg::ST_DONE))
      else $error("response raised outside the completion state");

   a_no_same_entry: assert property (@(posedge clock) disable iff (reset)
      (mem_re && mem_we) |-> (mem_raddr != mem_waddr))
      else $error("shift reads and writes the same entry");
`endif

endmodule

`default_nettype wire
